// File: sv/irac_pkg.sv
package irac_pkg;

	// Sizing defaults
	localparam int MAX_FRAME_BYTES_DEF = 16;
	localparam int LEN_W               = 5;
	localparam int STATE_FRAME_LEN     = 16;
	localparam int OFF_FRAME_LEN       = 7;
	localparam logic [15:0] UNIT_TICKS_RESET = 16'd412;

	// Operation codes
	typedef logic [1:0] op_t;
	localparam op_t OP_TICK     = 2'd0;
	localparam op_t OP_STATE    = 2'd1;
	localparam op_t OP_STATE_ON = 2'd2;
	localparam op_t OP_OFF      = 2'd3;

	// Register indexes
	localparam logic REG_UNIT_TICKS = 1'b0;

	// Fixed frame bytes
	localparam logic [7:0] HDR_0      = 8'h14;
	localparam logic [7:0] HDR_1      = 8'h63;
	localparam logic [7:0] HDR_2      = 8'h00;
	localparam logic [7:0] HDR_3      = 8'h10;
	localparam logic [7:0] ST_5       = 8'hFE;
	localparam logic [7:0] ST_6       = 8'h09;
	localparam logic [7:0] ST_7       = 8'h30;
	localparam logic [7:0] ST_14      = 8'h20;
	localparam logic [7:0] OFF_5      = 8'h02;
	localparam logic [7:0] OFF_6      = 8'hFD;
	localparam logic [7:0] SUM_FIXED  = 8'h50;

	typedef struct packed {
		logic [1:0] operation;
		logic [5:0] temperature;
		logic [2:0] ac_mode;
		logic [2:0] fan_speed;
		logic       swing_vert;
		logic       swing_horizontal;
	} cmd_t;

	typedef struct packed {
		logic ir_mark;
		logic busy_res;
		logic frame_done;
		logic rejected;
	} res_t;

	// Byte idx of the state frame, or of the power-off frame when off is set
	function automatic logic [7:0] frame_byte(
		input logic [3:0] idx,
		input logic       off,
		input logic [7:0] t_byte,
		input logic [7:0] m_byte,
		input logic [7:0] f_byte,
		input logic [7:0] c_byte
	);
		logic [7:0] b;
		b = 8'h00;
		case (idx) inside
			4'd0:               b = HDR_0;
			4'd1:               b = HDR_1;
			4'd2:               b = HDR_2;
			4'd3, 4'd4:         b = HDR_3;
			4'd5:               b = off ? OFF_5 : ST_5;
			4'd6:               b = off ? OFF_6 : ST_6;
			4'd7:               b = ST_7;
			4'd8:               b = t_byte;
			4'd9:               b = m_byte;
			4'd10:              b = f_byte;
			4'd14:              b = ST_14;
			4'd15:              b = c_byte;
			default:            b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// File: sv/irac_ram.sv
module irac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/ir_aircon_frame_transmitter_unit.sv
// Channel   Direction  Word              Handshake
// cmd       in         irac_pkg::cmd_t   cmd_valid / cmd_stall
// res       out        irac_pkg::res_t   res_valid / res_stall
// apb       in/out     unit_ticks        psel / penable / pwrite / pready
//
// One command word is taken every clock unless stalled; each gives one result word in
// the next cycle from the output register. A start fills the frame RAM with its 16 or
// 7 bytes, one byte per cycle through its single write port, running ahead of playout.
// Reset clears all control state and loads unit_ticks with 412; the RAM needs no clear.
// cmd_stall is high only while a result word sits in the output register under res_stall.
module ir_aircon_frame_transmitter_unit #(
	parameter int MAX_FRAME_BYTES = irac_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  irac_pkg::cmd_t cmd,
	output logic           res_valid,
	input  logic           res_stall,
	output irac_pkg::res_t res,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	localparam int AW = $clog2(MAX_FRAME_BYTES);
	localparam int LW = irac_pkg::LEN_W;
	localparam int STATE_LEN = (MAX_FRAME_BYTES < irac_pkg::STATE_FRAME_LEN) ?
		MAX_FRAME_BYTES : irac_pkg::STATE_FRAME_LEN;
	localparam logic [LW-1:0] STATE_LEN_V = LW'(STATE_LEN);
	localparam logic [LW-1:0] OFF_LEN_V   = LW'(irac_pkg::OFF_FRAME_LEN);

	typedef enum logic [2:0] {
		PH_IDLE, PH_LEAD_MARK, PH_LEAD_SPACE, PH_BIT_MARK,
		PH_BIT_SPACE, PH_TRAIL_MARK, PH_TRAIL_SPACE
	} phase_t;

	// Control state
	phase_t        phase_q, phase_nxt;
	logic [LW-1:0] byte_pos_q, byte_pos_nxt;
	logic [2:0]    bit_pos_q, bit_pos_nxt;
	logic [15:0]   tick_cnt_q, tick_cnt_nxt;
	logic [3:0]    units_q, units_nxt;
	logic [LW-1:0] frame_len_q, frame_len_nxt;
	logic [15:0]   unit_ticks_q;

	// Frame fill
	logic          wr_active_q;
	logic [LW-1:0] wr_idx_q;
	logic          wr_off_q;
	logic [7:0]    t_byte_q, m_byte_q, f_byte_q, c_byte_q;

	// Output register
	logic           res_valid_q;
	irac_pkg::res_t res_q, res_nxt;

	logic          cmd_acc, is_start, start_go, tick_go;
	logic          seg_end, done_nxt;
	logic [15:0]   cnt_inc;
	logic [3:0]    units_dec;
	logic [2:0]    bit_inc;
	logic [LW-1:0] byte_inc;
	logic [5:0]    temp_clamp;
	logic [7:0]    t_byte, m_byte, f_byte, c_byte;
	logic [7:0]    rd_byte;
	logic          ram_we;
	logic [7:0]    ram_wdata;

	assign cmd_stall = res_valid_q && res_stall;
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign is_start  = cmd.operation != irac_pkg::OP_TICK;
	assign start_go  = cmd_acc && is_start && (phase_q == PH_IDLE);
	assign tick_go   = cmd_acc && !is_start && (phase_q != PH_IDLE);

	// Build the variable bytes of the state frame
	always_comb begin
		if (cmd.temperature > 6'd31) begin
			temp_clamp = 6'd31;
		end else if (cmd.temperature < 6'd16) begin
			temp_clamp = 6'd16;
		end else begin
			temp_clamp = cmd.temperature;
		end
		t_byte = {temp_clamp[3:0], 3'b000, cmd.operation == irac_pkg::OP_STATE_ON};
		m_byte = {5'b00000, cmd.ac_mode};
		f_byte = {2'b00, cmd.swing_horizontal, cmd.swing_vert, 1'b0, cmd.fan_speed};
		c_byte = 8'h00 - (irac_pkg::SUM_FIXED + t_byte + m_byte + f_byte);
	end

	// Fill the frame RAM one byte per cycle after a start
	assign ram_we    = wr_active_q;
	assign ram_wdata = irac_pkg::frame_byte(wr_idx_q[3:0], wr_off_q,
		t_byte_q, m_byte_q, f_byte_q, c_byte_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_active_q <= 1'b0;
			wr_idx_q    <= '0;
		end else if (start_go) begin
			wr_active_q <= 1'b1;
			wr_idx_q    <= '0;
		end else if (wr_active_q) begin
			wr_idx_q <= wr_idx_q + 1'b1;
			if (wr_idx_q + 1'b1 == frame_len_q) begin
				wr_active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_go) begin
			wr_off_q <= cmd.operation == irac_pkg::OP_OFF;
			t_byte_q <= t_byte;
			m_byte_q <= m_byte;
			f_byte_q <= f_byte;
			c_byte_q <= c_byte;
		end
	end

	// Read ahead at the next byte position so the current byte is ready in every cycle
	irac_ram #(
		.WIDTH(8),
		.DEPTH(MAX_FRAME_BYTES)
	) u_frame_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_idx_q[AW-1:0]),
		.wdata(ram_wdata),
		.raddr(byte_pos_nxt[AW-1:0]),
		.rdata(rd_byte)
	);

	// Advance the envelope on ticks; load a frame on start
	assign cnt_inc   = tick_cnt_q + 16'd1;
	assign units_dec = units_q - 4'd1;
	assign seg_end   = (cnt_inc >= unit_ticks_q) && (units_dec == 4'd0);
	assign bit_inc   = bit_pos_q + 3'd1;
	assign byte_inc  = (bit_inc == 3'd0) ? byte_pos_q + 1'b1 : byte_pos_q;

	always_comb begin
		phase_nxt     = phase_q;
		byte_pos_nxt  = byte_pos_q;
		bit_pos_nxt   = bit_pos_q;
		tick_cnt_nxt  = tick_cnt_q;
		units_nxt     = units_q;
		frame_len_nxt = frame_len_q;
		done_nxt      = 1'b0;
		if (start_go) begin
			frame_len_nxt = (cmd.operation == irac_pkg::OP_OFF) ? OFF_LEN_V : STATE_LEN_V;
			byte_pos_nxt  = '0;
			bit_pos_nxt   = '0;
			tick_cnt_nxt  = '0;
			phase_nxt     = PH_LEAD_MARK;
			units_nxt     = 4'd8;
		end else if (tick_go) begin
			tick_cnt_nxt = cnt_inc;
			if (cnt_inc >= unit_ticks_q) begin
				tick_cnt_nxt = '0;
				units_nxt    = units_dec;
			end
			if (seg_end) begin
				unique case (phase_q)
					PH_LEAD_MARK: begin
						phase_nxt = PH_LEAD_SPACE;
						units_nxt = 4'd4;
					end
					PH_LEAD_SPACE: begin
						phase_nxt = (frame_len_q == '0) ? PH_TRAIL_MARK : PH_BIT_MARK;
						units_nxt = 4'd1;
					end
					PH_BIT_MARK: begin
						phase_nxt = PH_BIT_SPACE;
						units_nxt = rd_byte[bit_pos_q] ? 4'd1 : 4'd3;
					end
					PH_BIT_SPACE: begin
						bit_pos_nxt  = bit_inc;
						byte_pos_nxt = byte_inc;
						phase_nxt    = (byte_inc >= frame_len_q) ? PH_TRAIL_MARK : PH_BIT_MARK;
						units_nxt    = 4'd1;
					end
					PH_TRAIL_MARK: begin
						phase_nxt = PH_TRAIL_SPACE;
						units_nxt = 4'd4;
					end
					default: begin
						phase_nxt    = PH_IDLE;
						units_nxt    = '0;
						tick_cnt_nxt = '0;
						byte_pos_nxt = '0;
						bit_pos_nxt  = '0;
						done_nxt     = 1'b1;
					end
				endcase
			end
		end
		res_nxt.ir_mark    = (phase_nxt == PH_LEAD_MARK) || (phase_nxt == PH_BIT_MARK) ||
			(phase_nxt == PH_TRAIL_MARK);
		res_nxt.busy_res   = phase_nxt != PH_IDLE;
		res_nxt.frame_done = done_nxt;
		res_nxt.rejected   = cmd_acc && is_start && (phase_q != PH_IDLE);
	end

	// Hold state and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			byte_pos_q  <= '0;
			bit_pos_q   <= '0;
			tick_cnt_q  <= '0;
			units_q     <= '0;
			frame_len_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			phase_q     <= phase_nxt;
			byte_pos_q  <= byte_pos_nxt;
			bit_pos_q   <= bit_pos_nxt;
			tick_cnt_q  <= tick_cnt_nxt;
			units_q     <= units_nxt;
			frame_len_q <= frame_len_nxt;
			if (!cmd_stall) begin
				res_valid_q <= cmd_acc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Register port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_ticks_q <= irac_pkg::UNIT_TICKS_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == irac_pkg::REG_UNIT_TICKS)) begin
			unit_ticks_q <= pwdata[15:0];
		end
	end

	assign prdata = (paddr[2] == irac_pkg::REG_UNIT_TICKS) ? {16'h0000, unit_ticks_q} : '0;

`ifndef ASSERT_OFF
	a_fill_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr_active_q |-> phase_q != PH_IDLE)
		else $error("frame fill running while idle");

	a_byte_written_before_read: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_go && seg_end && phase_q == PH_BIT_MARK && wr_active_q)
		|-> ({1'b0, byte_pos_q} + 6'd1 < {1'b0, wr_idx_q}))
		else $error("frame byte read before it was written");

	a_reject_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.rejected) |-> res_q.busy_res)
		else $error("start rejected while idle");

	a_done_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.frame_done) |-> (!res_q.busy_res && !res_q.ir_mark))
		else $error("frame done while still sending");
`endif

endmodule
